### hw/rtl/rhc_pkg.sv
// Shared widths, payload types and sector codes of the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

  localparam int unsigned CHANNEL_BITS  = 8;
  localparam int unsigned FRACTION_BITS = 16;

  // Hue: dividend is num * 2^F + 3d with num < 6d, divisor is 6d.
  localparam int unsigned HUE_DEN_BITS = CHANNEL_BITS + 3;
  localparam int unsigned HUE_NUM_BITS = HUE_DEN_BITS + FRACTION_BITS;
  // Saturation: dividend is d * (2^F - 1) + max / 2, divisor is max.
  localparam int unsigned SAT_DEN_BITS = CHANNEL_BITS;
  localparam int unsigned SAT_NUM_BITS = CHANNEL_BITS + FRACTION_BITS;
  // One extra quotient bit catches the full-turn case before saturation.
  localparam int unsigned QUO_BITS     = FRACTION_BITS + 1;
  localparam int unsigned DIV_STEPS    = 4;
  localparam int unsigned DIV_STAGES   = (QUO_BITS + DIV_STEPS - 1) / DIV_STEPS;

  localparam logic [FRACTION_BITS-1:0] FRAC_MAX = {FRACTION_BITS{1'b1}};

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_e;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [FRACTION_BITS-1:0] hue;
    logic [FRACTION_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0]  brightness;
  } hsv_t;

  // Data that rides alongside the dividers.
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] brightness;
    logic                    hue_zero;
    logic                    sat_zero;
  } side_t;

  typedef struct packed {
    logic [HUE_NUM_BITS-1:0] hue_num;
    logic [HUE_DEN_BITS-1:0] hue_den;
    logic [SAT_NUM_BITS-1:0] sat_num;
    logic [SAT_DEN_BITS-1:0] sat_den;
    side_t                   side;
  } front_t;

endpackage

`default_nettype wire

### hw/rtl/rhc_front.sv
// Front end: max/min and sector pick, then hue and saturation dividend setup.
`default_nettype none

module rhc_front
  import rhc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  input  wire pixel_t pixel_i,
  output logic        valid_o,
  output front_t      front_o
);

  localparam int unsigned C = CHANNEL_BITS;
  localparam int unsigned F = FRACTION_BITS;

  // Stage one registers.
  logic                 valid1_q;
  pixel_t               pix_q;
  logic [C-1:0]         hi_q, hi_d;
  logic [C-1:0]         lo_q, lo_d;
  sector_e              sector_q, sector_d;

  // Stage two registers.
  logic                 valid2_q;
  front_t               front_q, front_d;

  always_comb begin
    if (pixel_i.red >= pixel_i.green && pixel_i.red >= pixel_i.blue) begin
      sector_d = SECTOR_RED;
      hi_d     = pixel_i.red;
    end else if (pixel_i.green >= pixel_i.blue) begin
      sector_d = SECTOR_GREEN;
      hi_d     = pixel_i.green;
    end else begin
      sector_d = SECTOR_BLUE;
      hi_d     = pixel_i.blue;
    end
    lo_d = pixel_i.red;
    if (pixel_i.green < lo_d) lo_d = pixel_i.green;
    if (pixel_i.blue < lo_d) lo_d = pixel_i.blue;
  end

  logic [C-1:0]            d;
  logic [HUE_DEN_BITS-1:0] dx, r_x, g_x, b_x, d3, num;

  always_comb begin
    d   = hi_q - lo_q;
    dx  = HUE_DEN_BITS'(d);
    r_x = HUE_DEN_BITS'(pix_q.red);
    g_x = HUE_DEN_BITS'(pix_q.green);
    b_x = HUE_DEN_BITS'(pix_q.blue);
    d3  = (dx << 1) + dx;
    // Each sector lands num in [0, 6d); modular arithmetic covers the
    // intermediate negative differences.
    case (sector_q)
      SECTOR_RED: begin
        if (pix_q.green >= pix_q.blue) num = g_x - b_x;
        else num = (d3 << 1) - (b_x - g_x);
      end
      SECTOR_GREEN: num = (dx << 1) + b_x - r_x;
      SECTOR_BLUE:  num = (dx << 2) + r_x - g_x;
      default:      num = '0;
    endcase
    front_d.hue_num = {num, {F{1'b0}}} + HUE_NUM_BITS'(d3);
    front_d.hue_den = d3 << 1;
    front_d.sat_num = {d, {F{1'b0}}} - SAT_NUM_BITS'(d) + SAT_NUM_BITS'(hi_q >> 1);
    front_d.sat_den = hi_q;
    front_d.side.brightness = hi_q;
    front_d.side.hue_zero   = (d == '0);
    front_d.side.sat_zero   = (hi_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q    <= pixel_i;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    sector_q <= sector_d;
    front_q  <= front_d;
  end

  assign valid_o = valid2_q;
  assign front_o = front_q;

endmodule

`default_nettype wire

### hw/rtl/rhc_div_pipe.sv
// Pipelined restoring divider, up to STEPS quotient bits per stage.
`default_nettype none

module rhc_div_pipe
  import rhc_pkg::*;
#(
  parameter int unsigned NUM_BITS = HUE_NUM_BITS,
  parameter int unsigned DEN_BITS = HUE_DEN_BITS,
  parameter int unsigned Q_BITS   = QUO_BITS,
  parameter int unsigned STEPS    = DIV_STEPS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire logic [NUM_BITS-1:0] dividend_i,
  input  wire logic [DEN_BITS-1:0] divisor_i,
  output logic                     valid_o,
  output logic [Q_BITS-1:0]        quotient_o
);

  localparam int unsigned STAGES = (Q_BITS + STEPS - 1) / STEPS;

  // The caller guarantees dividend < divisor * 2^Q_BITS, so the top part of
  // the dividend is already a valid partial remainder.
  logic                valid_q [STAGES];
  logic [DEN_BITS-1:0] rem_q   [STAGES];
  logic [DEN_BITS-1:0] dsr_q   [STAGES];
  logic [Q_BITS-1:0]   low_q   [STAGES];
  logic [Q_BITS-1:0]   quo_q   [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                valid_in;
    logic [DEN_BITS-1:0] rem_in, dsr_in;
    logic [Q_BITS-1:0]   low_in, quo_in;
    logic [DEN_BITS-1:0] rem_d;
    logic [Q_BITS-1:0]   low_d, quo_d;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = DEN_BITS'(dividend_i[NUM_BITS-1:Q_BITS]);
      assign dsr_in   = divisor_i;
      assign low_in   = dividend_i[Q_BITS-1:0];
      assign quo_in   = '0;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign dsr_in   = dsr_q[s-1];
      assign low_in   = low_q[s-1];
      assign quo_in   = quo_q[s-1];
    end

    always_comb begin
      logic [DEN_BITS:0] trial;
      logic [DEN_BITS:0] diff;
      rem_d = rem_in;
      low_d = low_in;
      quo_d = quo_in;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < Q_BITS) begin
          trial = {rem_d, low_d[Q_BITS-1]};
          diff  = trial - {1'b0, dsr_in};
          low_d = low_d << 1;
          if (trial >= {1'b0, dsr_in}) begin
            rem_d = diff[DEN_BITS-1:0];
            quo_d = {quo_d[Q_BITS-2:0], 1'b1};
          end else begin
            rem_d = trial[DEN_BITS-1:0];
            quo_d = {quo_d[Q_BITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      dsr_q[s] <= dsr_in;
      low_q[s] <= low_d;
      quo_q[s] <= quo_d;
    end
  end

  assign valid_o    = valid_q[STAGES-1];
  assign quotient_o = quo_q[STAGES-1];

endmodule

`default_nettype wire

### hw/rtl/rgb_to_hsv_converter_unit.sv
// Top level of the RGB to HSV converter: front end, two dividers, output stage.
`default_nettype none

// Converts one RGB pixel (8-bit channels) to an 8-bit value and to hue and
// saturation in fixed point (16-bit fractions). A pixel is taken on every
// clock edge where start_i is high; busy_o never rises, so one pixel per clock
// is sustained. Each result appears on result_o for one cycle, flagged by
// result_valid_o, once its pixel has passed the front-end registers, the
// divider stages and the output register, and is transferred at the edge that
// ends that cycle. The two pipelined dividers resolve up to DIV_STEPS of the
// 17 quotient bits per stage; the receiver has no way to stall and must take
// every result in the cycle it is shown.
module rgb_to_hsv_converter_unit
  import rhc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start_i,
  input  wire pixel_t pixel_i,
  output logic        busy_o,
  output logic        result_valid_o,
  output hsv_t        result_o
);

  logic                front_valid;
  front_t              front;
  logic                hue_valid, sat_valid;
  logic [QUO_BITS-1:0] hue_quo, sat_quo;

  side_t               side_q [DIV_STAGES];
  logic                result_valid_q;
  hsv_t                result_q, result_d;

  assign busy_o = 1'b0;

  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .pixel_i (pixel_i),
    .valid_o (front_valid),
    .front_o (front)
  );

  rhc_div_pipe #(
    .NUM_BITS (HUE_NUM_BITS),
    .DEN_BITS (HUE_DEN_BITS),
    .Q_BITS   (QUO_BITS),
    .STEPS    (DIV_STEPS)
  ) u_hue_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (front_valid),
    .dividend_i (front.hue_num),
    .divisor_i  (front.hue_den),
    .valid_o    (hue_valid),
    .quotient_o (hue_quo)
  );

  rhc_div_pipe #(
    .NUM_BITS (SAT_NUM_BITS),
    .DEN_BITS (SAT_DEN_BITS),
    .Q_BITS   (QUO_BITS),
    .STEPS    (DIV_STEPS)
  ) u_sat_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (front_valid),
    .dividend_i (front.sat_num),
    .divisor_i  (front.sat_den),
    .valid_o    (sat_valid),
    .quotient_o (sat_quo)
  );

  // Side data follows the dividers stage by stage.
  always_ff @(posedge clk_i) begin
    side_q[0] <= front.side;
    for (int s = 1; s < DIV_STAGES; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  // Grey and black pixels divide by zero and are forced here; overflow clamps.
  always_comb begin
    if (side_q[DIV_STAGES-1].hue_zero) begin
      result_d.hue = '0;
    end else if (hue_quo[QUO_BITS-1]) begin
      result_d.hue = FRAC_MAX;
    end else begin
      result_d.hue = hue_quo[FRACTION_BITS-1:0];
    end
    if (side_q[DIV_STAGES-1].sat_zero) begin
      result_d.saturation = '0;
    end else if (sat_quo[QUO_BITS-1]) begin
      result_d.saturation = FRAC_MAX;
    end else begin
      result_d.saturation = sat_quo[FRACTION_BITS-1:0];
    end
    result_d.brightness = side_q[DIV_STAGES-1].brightness;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= hue_valid & sat_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire

### verif/rgb_to_hsv_converter_unit_tb.sv
// Self-checking testbench for the RGB to HSV converter unit.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_unit_tb
  import rhc_pkg::*;
();

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned RANDOM_PIXELS = 1030;

  class hsv_scoreboard;
    hsv_t        expected_hsv[$];
    int unsigned mismatches;
    int unsigned pixels_seen;
    int unsigned results_checked;
    int unsigned sector_hits[3];
    int unsigned grey_hits;

    function new();
      mismatches      = 0;
      pixels_seen     = 0;
      results_checked = 0;
      grey_hits       = 0;
      foreach (sector_hits[i]) sector_hits[i] = 0;
    endfunction

    // Fixed-point conversion of one pixel; also tells which channel won.
    function hsv_t convert(input pixel_t px, output sector_e sector);
      longint unsigned r, g, b, hi, lo, d, num, hue, sat, frac_max;
      hsv_t res;
      frac_max = (longint'(1) << FRACTION_BITS) - 1;
      r = 64'(px.red);
      g = 64'(px.green);
      b = 64'(px.blue);
      // Red wins every tie for the largest channel, and green beats blue.
      if (r >= g && r >= b) begin
        sector = SECTOR_RED;
        hi = r;
      end else if (g >= b) begin
        sector = SECTOR_GREEN;
        hi = g;
      end else begin
        sector = SECTOR_BLUE;
        hi = b;
      end
      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      d = hi - lo;
      if (d == 0) begin
        hue = 0;
      end else begin
        // num / (6d) is the hue as a fraction of a turn, num in [0, 6d).
        case (sector)
          SECTOR_RED:   num = (g >= b) ? g - b : 6 * d - (b - g);
          SECTOR_GREEN: num = 2 * d + b - r;
          default:      num = 4 * d + r - g;
        endcase
        hue = ((num << FRACTION_BITS) + 3 * d) / (6 * d);
        if (hue > frac_max) hue = frac_max;
      end
      if (hi == 0) sat = 0;
      else sat = (d * frac_max + hi / 2) / hi;
      if (sat > frac_max) sat = frac_max;
      res.hue        = hue[FRACTION_BITS-1:0];
      res.saturation = sat[FRACTION_BITS-1:0];
      res.brightness = hi[CHANNEL_BITS-1:0];
      return res;
    endfunction

    function void note_pixel(pixel_t px);
      sector_e sector;
      expected_hsv.push_back(convert(px, sector));
      pixels_seen++;
      sector_hits[sector]++;
      if (px.red == px.green && px.green == px.blue) grey_hits++;
    endfunction

    function int unsigned pending();
      return expected_hsv.size();
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(hsv_t got);
      hsv_t want;
      if (expected_hsv.size() == 0) begin
        report_mismatch("unexpected result (brightness shown)", 64'(got.brightness), 0);
      end else begin
        want = expected_hsv.pop_front();
        results_checked++;
        if (got.hue !== want.hue)
          report_mismatch("hue", 64'(got.hue), 64'(want.hue));
        if (got.saturation !== want.saturation)
          report_mismatch("saturation", 64'(got.saturation), 64'(want.saturation));
        if (got.brightness !== want.brightness)
          report_mismatch("brightness", 64'(got.brightness), 64'(want.brightness));
      end
    endtask

    task check_drained();
      if (expected_hsv.size() != 0)
        report_mismatch("results never delivered", 0, 64'(expected_hsv.size()));
    endtask
  endclass

  logic   clk_i   = 1'b0;
  logic   rst_ni  = 1'b0;
  logic   start_i = 1'b0;
  pixel_t pixel_i = '0;
  logic   busy_o;
  logic   result_valid_o;
  hsv_t   result_o;

  hsv_scoreboard sb = new();
  int unsigned   idle_cycles = 0;

  rgb_to_hsv_converter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .pixel_i        (pixel_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: notes every pixel transfer and checks every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_pixel(pixel_i);
      if (result_valid_o) sb.check_result(result_o);
      if ((start_i && !busy_o) || result_valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[%0t] timeout: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("rgb_to_hsv_converter_unit_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic pixel_t rgb(int unsigned r, int unsigned g, int unsigned b);
    pixel_t px;
    px.red   = r[CHANNEL_BITS-1:0];
    px.green = g[CHANNEL_BITS-1:0];
    px.blue  = b[CHANNEL_BITS-1:0];
    return px;
  endfunction

  // Drives one pixel after a random gap and returns once it is transferred.
  task automatic send_pixel(pixel_t px);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned edge_value();
    int unsigned pick;
    pick = $urandom_range(0, 6);
    case (pick)
      0: return 0;
      1: return 1;
      2: return 127;
      3: return 128;
      4: return 254;
      5: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    pixel_t      directed[$];
    pixel_t      px;
    int unsigned mode;
    int unsigned top;
    int unsigned low;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    directed = '{
      rgb(0, 0, 0), rgb(255, 255, 255), rgb(128, 128, 128), rgb(1, 1, 1),
      rgb(255, 0, 0), rgb(0, 255, 0), rgb(0, 0, 255),
      rgb(255, 255, 0), rgb(0, 255, 255), rgb(255, 0, 255),
      rgb(200, 200, 17), rgb(200, 17, 200), rgb(17, 200, 200),
      rgb(255, 0, 1), rgb(255, 1, 0), rgb(1, 0, 0), rgb(0, 0, 1),
      rgb(0, 1, 0), rgb(128, 127, 126), rgb(170, 85, 0),
      rgb(255, 254, 255), rgb(85, 170, 255)
    };
    foreach (directed[i]) send_pixel(directed[i]);
    wait_drained();

    for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        px = rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (mode <= 7) begin
        px = rgb(edge_value(), edge_value(), edge_value());
      end else if (mode == 8) begin
        top = $urandom_range(0, 255);
        px = rgb(top, top, top);
      end else begin
        // Two channels share the maximum, the third sits below it.
        top = $urandom_range(1, 255);
        low = $urandom_range(0, top - 1);
        case ($urandom_range(0, 2))
          0:       px = rgb(top, top, low);
          1:       px = rgb(top, low, top);
          default: px = rgb(low, top, top);
        endcase
      end
      send_pixel(px);
      if (n == RANDOM_PIXELS / 2) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.check_drained();

    $display("Checked %0d results from %0d pixels (%0d grey).",
             sb.results_checked, sb.pixels_seen, sb.grey_hits);
    $display("Winning channel counts: red %0d, green %0d, blue %0d; %0d mismatches.",
             sb.sector_hits[SECTOR_RED], sb.sector_hits[SECTOR_GREEN],
             sb.sector_hits[SECTOR_BLUE], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("rgb_to_hsv_converter_unit_tb: PASS");
    end else begin
      $display("rgb_to_hsv_converter_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
